// File: rtl/scmm_pkg.sv
// Shared types and constants for the stereo channel mode mixer.
package scmm_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned GainW   = 32;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned IdxW    = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_STEREO     = 3'd0,
    MODE_MONO       = 3'd1,
    MODE_CUSTOM     = 3'd2,
    MODE_MONO_LEFT  = 3'd3,
    MODE_MONO_RIGHT = 3'd4,
    MODE_KARAOKE    = 3'd5
  } mode_e;

  typedef enum logic [IdxW-1:0] {
    REG_MODE     = 2'd0,
    REG_STRAIGHT = 2'd1,
    REG_CROSS    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [GainW-1:0]  straight_gain;
    logic [GainW-1:0]  cross_gain;
  } cfg_t;

endpackage

// File: rtl/stereo_channel_mode_mixer_top.sv
// Top level of the stereo channel mode mixer.
//
// Sample channel: a stereo pair is taken on left_sample_i/right_sample_i
// at each rising edge where start is high and busy is low. busy is
// always low, so a pair can be taken in every cycle.
// Result channel: the mixed pair appears on left_out_o/right_out_o for
// exactly one cycle, marked by done_o, once the pair has passed the
// input register and then the result register. Throughput is one pair
// per cycle; the four Q31 products of custom mode are formed in parallel
// between the two registers.
// Configuration: APB port, mode at 0x0, straight gain at 0x4, cross gain
// at 0x8; write only while no transaction is in flight. pready is always
// high. Writes to 0xC are dropped.
// Reset: clears config and valid flops (stereo pass-through), drops any
// transaction in flight. The receiver cannot stall: done_o is not held.
module stereo_channel_mode_mixer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [scmm_pkg::AddrW-1:0]          paddr,
  input  logic [scmm_pkg::DataW-1:0]          pwdata,
  output logic [scmm_pkg::DataW-1:0]          prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [scmm_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [scmm_pkg::SampleW-1:0] right_sample_i,
  output logic                                done_o,
  output logic signed [scmm_pkg::SampleW-1:0] left_out_o,
  output logic signed [scmm_pkg::SampleW-1:0] right_out_o
);

  scmm_pkg::cfg_t cfg;
  logic           start_acc;

  assign busy      = 1'b0;
  assign start_acc = start && !busy;

  scmm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scmm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start_i        (start_acc),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .done_o         (done_o),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o)
  );

endmodule

// File: rtl/scmm_apb_regs.sv
// APB configuration registers: mode, straight gain and cross gain.
module scmm_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scmm_pkg::AddrW-1:0]  paddr,
  input  logic [scmm_pkg::DataW-1:0]  pwdata,
  output logic [scmm_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output scmm_pkg::cfg_t              cfg_o
);

  logic [scmm_pkg::ModeW-1:0] mode_q,     mode_d;
  logic [scmm_pkg::GainW-1:0] straight_q, straight_d;
  logic [scmm_pkg::GainW-1:0] cross_q,    cross_d;
  logic                       wr_en;
  scmm_pkg::reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = scmm_pkg::reg_idx_e'(paddr[scmm_pkg::AddrW-1:2]);

  always_comb begin
    mode_d     = mode_q;
    straight_d = straight_q;
    cross_d    = cross_q;
    if (wr_en) begin
      case (idx)
        scmm_pkg::REG_MODE:     mode_d     = pwdata[scmm_pkg::ModeW-1:0];
        scmm_pkg::REG_STRAIGHT: straight_d = pwdata[scmm_pkg::GainW-1:0];
        scmm_pkg::REG_CROSS:    cross_d    = pwdata[scmm_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      scmm_pkg::REG_MODE:
        prdata = {{(scmm_pkg::DataW-scmm_pkg::ModeW){1'b0}}, mode_q};
      scmm_pkg::REG_STRAIGHT: prdata = straight_q;
      scmm_pkg::REG_CROSS:    prdata = cross_q;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      straight_q <= '0;
      cross_q    <= '0;
    end else begin
      mode_q     <= mode_d;
      straight_q <= straight_d;
      cross_q    <= cross_d;
    end
  end

  assign cfg_o.mode          = mode_q;
  assign cfg_o.straight_gain = straight_q;
  assign cfg_o.cross_gain    = cross_q;

endmodule

// File: rtl/scmm_datapath.sv
// Sample datapath: input register, channel-mode mixing logic, result register.
module scmm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  scmm_pkg::cfg_t                      cfg_i,
  input  logic                                start_i,
  input  logic signed [scmm_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [scmm_pkg::SampleW-1:0] right_sample_i,
  output logic                                done_o,
  output logic signed [scmm_pkg::SampleW-1:0] left_out_o,
  output logic signed [scmm_pkg::SampleW-1:0] right_out_o
);

  localparam int unsigned W  = scmm_pkg::SampleW;
  localparam int unsigned PW = scmm_pkg::SampleW + scmm_pkg::GainW;

  logic                vld_q, vld_d;
  logic signed [W-1:0] l_q, r_q;
  logic                done_q, done_d;
  logic signed [W-1:0] lo_q, lo_d, ro_q, ro_d;

  logic signed [scmm_pkg::GainW-1:0] g, c;
  logic signed [PW-1:0]  p_lg, p_rc, p_rg, p_lc;
  logic        [W-1:0]   cust_l, cust_r;
  logic signed [W:0]     l_ext, r_ext;
  logic signed [W-1:0]   l_half, r_half, mono, kar;
  logic signed [W:0]     l_tmp, r_tmp;
  scmm_pkg::mode_e       mode;

  assign g    = cfg_i.straight_gain;
  assign c    = cfg_i.cross_gain;
  assign mode = scmm_pkg::mode_e'(cfg_i.mode);

  assign p_lg = l_q * g;
  assign p_rc = r_q * c;
  assign p_rg = r_q * g;
  assign p_lc = l_q * c;

  assign cust_l = p_lg[PW-2:W-1] + p_rc[PW-2:W-1];
  assign cust_r = p_rg[PW-2:W-1] + p_lc[PW-2:W-1];

  // halve toward zero: bias negatives by one before the shift
  assign l_ext  = {l_q[W-1], l_q};
  assign r_ext  = {r_q[W-1], r_q};
  assign l_tmp  = (l_ext + {{W{1'b0}}, l_q[W-1]}) >>> 1;
  assign r_tmp  = (r_ext + {{W{1'b0}}, r_q[W-1]}) >>> 1;
  assign l_half = l_tmp[W-1:0];
  assign r_half = r_tmp[W-1:0];
  assign mono   = l_half + r_half;
  assign kar    = l_half - r_half;

  always_comb begin
    vld_d  = start_i;
    done_d = vld_q;
    lo_d   = l_q;
    ro_d   = r_q;
    case (mode)
      scmm_pkg::MODE_MONO: begin
        lo_d = mono;
        ro_d = mono;
      end
      scmm_pkg::MODE_CUSTOM: begin
        lo_d = cust_l;
        ro_d = cust_r;
      end
      scmm_pkg::MODE_MONO_LEFT:  ro_d = l_q;
      scmm_pkg::MODE_MONO_RIGHT: lo_d = r_q;
      scmm_pkg::MODE_KARAOKE: begin
        lo_d = kar;
        ro_d = -kar;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      l_q <= left_sample_i;
      r_q <= right_sample_i;
    end
    if (vld_q) begin
      lo_q <= lo_d;
      ro_q <= ro_d;
    end
  end

  assign done_o      = done_q;
  assign left_out_o  = lo_q;
  assign right_out_o = ro_q;

endmodule

// File: test/scmm_checker.sv
// Checker for the stereo channel mode mixer: tracks configuration, predicts and compares pairs.
`timescale 1ns / 100ps

module scmm_checker
  import scmm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [AddrW-1:0]          paddr_i,
  input  logic [DataW-1:0]          pwdata_i,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic signed [SampleW-1:0] left_sample_i,
  input  logic signed [SampleW-1:0] right_sample_i,
  input  logic                      done_i,
  input  logic signed [SampleW-1:0] left_out_i,
  input  logic signed [SampleW-1:0] right_out_i,
  output int                        err_cnt_o,
  output int                        pending_o
);

  typedef struct {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } mixed_pair_t;

  mixed_pair_t              expected_pairs[$];
  mixed_pair_t              want;
  mixed_pair_t              fresh;
  logic [ModeW-1:0]         cfg_mode;
  logic signed [GainW-1:0]  cfg_straight;
  logic signed [GainW-1:0]  cfg_cross;

  task automatic report_mismatch(input string what, input logic [SampleW-1:0] got,
                                 input logic [SampleW-1:0] exp_val);
    $display("%0t scmm_checker: %s got %08h want %08h", $time, what, got, exp_val);
    err_cnt_o++;
  endtask

  function automatic logic signed [SampleW-1:0] q31_mul(input logic signed [SampleW-1:0] a,
                                                         input logic signed [GainW-1:0] b);
    logic signed [63:0] prod;
    prod = a * b;
    return prod[62:31];
  endfunction

  function automatic logic signed [SampleW-1:0] half_tz(input logic signed [SampleW-1:0] x);
    return x / 2;
  endfunction

  function automatic mixed_pair_t mix_pair(input logic [ModeW-1:0] mode,
                                           input logic signed [GainW-1:0] g,
                                           input logic signed [GainW-1:0] c,
                                           input logic signed [SampleW-1:0] l,
                                           input logic signed [SampleW-1:0] r);
    mixed_pair_t res;
    logic signed [SampleW-1:0] diff;
    res.left  = l;
    res.right = r;
    case (mode)
      MODE_MONO: begin
        res.left  = half_tz(l) + half_tz(r);
        res.right = res.left;
      end
      MODE_CUSTOM: begin
        res.left  = q31_mul(l, g) + q31_mul(r, c);
        res.right = q31_mul(r, g) + q31_mul(l, c);
      end
      MODE_MONO_LEFT:  res.right = l;
      MODE_MONO_RIGHT: res.left  = r;
      MODE_KARAOKE: begin
        diff      = half_tz(l) - half_tz(r);
        res.left  = diff;
        res.right = -diff;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pairs.delete();
      cfg_mode     = '0;
      cfg_straight = '0;
      cfg_cross    = '0;
      pending_o    = 0;
    end else begin
      if (done_i) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("result without transaction", left_out_i, 'x);
        end else begin
          want = expected_pairs.pop_front();
          if (left_out_i !== want.left) begin
            report_mismatch("left_out", left_out_i, want.left);
          end
          if (right_out_i !== want.right) begin
            report_mismatch("right_out", right_out_i, want.right);
          end
        end
      end
      if (start_i && !busy_i) begin
        fresh = mix_pair(cfg_mode, cfg_straight, cfg_cross, left_sample_i, right_sample_i);
        expected_pairs.push_back(fresh);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          REG_MODE:     cfg_mode     = pwdata_i[ModeW-1:0];
          REG_STRAIGHT: cfg_straight = pwdata_i;
          REG_CROSS:    cfg_cross    = pwdata_i;
          default: ;
        endcase
      end
      pending_o = expected_pairs.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the stereo channel mode mixer: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module tb_top;
  import scmm_pkg::*;

  localparam logic signed [SampleW-1:0] SampleMin = 32'sh8000_0000;
  localparam logic signed [SampleW-1:0] SampleMax = 32'sh7fff_ffff;
  localparam logic [IdxW-1:0]           RegUnused = 2'd3;
  localparam int                        PhaseCnt  = 22;
  localparam int                        PhaseLen  = 75;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [AddrW-1:0]          paddr;
  logic [DataW-1:0]          pwdata;
  logic [DataW-1:0]          prdata;
  logic                      pready;
  logic                      start;
  logic                      busy;
  logic signed [SampleW-1:0] left_sample;
  logic signed [SampleW-1:0] right_sample;
  logic                      done;
  logic signed [SampleW-1:0] left_out;
  logic signed [SampleW-1:0] right_out;
  int                        err_cnt;
  int                        pending;

  stereo_channel_mode_mixer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .done_o         (done),
    .left_out_o     (left_out),
    .right_out_o    (right_out)
  );

  scmm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .start_i        (start),
    .busy_i         (busy),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .done_i         (done),
    .left_out_i     (left_out),
    .right_out_i    (right_out),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
    drain_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_pair(input logic signed [SampleW-1:0] l,
                           input logic signed [SampleW-1:0] r);
    @(negedge clk_i);
    start        <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SampleMin;
      1: return SampleMax;
      2: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return SampleMin;
      1: return SampleMax;
      2: return '0;
      3: return 32'h4000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int  m;
    bit  quiet;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    start        = 1'b0;
    left_sample  = '0;
    right_sample = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(REG_STRAIGHT, SampleMin);
    cfg_write(REG_CROSS, SampleMin);
    for (int mode_val = 0; mode_val < 8; mode_val++) begin
      cfg_write(REG_MODE, mode_val);
      send_pair(SampleMin, SampleMax);
      send_pair(SampleMax, SampleMin);
      send_pair(-3, 5);
    end
    cfg_write(REG_MODE, DataW'(MODE_CUSTOM));
    send_pair(SampleMin, SampleMin);
    cfg_write(RegUnused, SampleMax);
    cfg_write(REG_STRAIGHT, SampleMax);
    cfg_write(REG_CROSS, '0);
    send_pair(SampleMax, -1);
    send_pair(SampleMin, SampleMax);

    for (int ph = 0; ph < PhaseCnt; ph++) begin
      m = $urandom_range(0, 11);
      if (m > 7) m = int'(MODE_CUSTOM);
      cfg_write(REG_MODE, ($urandom & ~32'h7) | m);
      cfg_write(REG_STRAIGHT, rand_gain());
      cfg_write(REG_CROSS, rand_gain());
      if ($urandom_range(0, 5) == 0) cfg_write(RegUnused, $urandom);
      quiet = 1'b0;
      for (int i = 0; i < PhaseLen; i++) begin
        if (i % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
        if (ph == PhaseCnt / 2 && i == PhaseLen / 2) drain_results();
        idle_gap(pick_gap(quiet));
        send_pair(rand_sample(), rand_sample());
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/scmm_pkg.sv
rtl/scmm_apb_regs.sv
rtl/scmm_datapath.sv
rtl/stereo_channel_mode_mixer_top.sv
test/scmm_checker.sv
test/tb_top.sv
